### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the maze core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define GMZ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// checked at every edge, reset included
`define GMZ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error(msg);

`endif

### rtl/core/gmz_pkg.sv
// ----------------------------------------------------------------------------
// gmz_pkg
// types and constants shared by the maze core and its pick unit
// ----------------------------------------------------------------------------
package gmz_pkg;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_GEN   = 2'd1;
   localparam logic [1:0] CMD_SOLVE = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam logic [1:0] DIR_TOP    = 2'd0;
   localparam logic [1:0] DIR_RIGHT  = 2'd1;
   localparam logic [1:0] DIR_BOTTOM = 2'd2;
   localparam logic [1:0] DIR_LEFT   = 2'd3;

   localparam int unsigned LFSR_WIDTH = 16;
   localparam logic [LFSR_WIDTH-1:0] LFSR_TAPS = 16'hB400;
   localparam logic [LFSR_WIDTH-1:0] LFSR_ONE  = 16'h0001;

   localparam logic [3:0] WALL_ALL = 4'hF;

   typedef struct packed {
      logic [3:0] walls;
      logic       visited;
      logic       path;
   } cell_type;

   typedef struct packed {
      logic                  load;
      logic                  step;
      logic [LFSR_WIDTH-1:0] seed;
   } pick_ctl_type;

endpackage

### rtl/core/gmz_pick.sv
// ----------------------------------------------------------------------------
// gmz_pick
// random direction pick: lfsr stepped once per pick, index lfsr mod count
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gmz_pick (
   input  logic                 clock,
   input  logic                 reset,
   input  gmz_pkg::pick_ctl_type ctl,
   input  logic [3:0]           mask,
   output logic [1:0]           dir
);

   logic [gmz_pkg::LFSR_WIDTH-1:0] lfsr_ff, lfsr_in, lfsr_nx;
   logic [1:0] dir_ff, dir_in;
   logic [2:0] count;
   logic [1:0] idx;

   function automatic logic [1:0] mod3(input logic [15:0] v);
      logic [4:0] s;
      logic [2:0] t;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s = s + 5'(v[2*i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      if (t >= 3'd6) begin
         t = t - 3'd6;
      end else if (t >= 3'd3) begin
         t = t - 3'd3;
      end
      return t[1:0];
   endfunction

   always_comb begin
      lfsr_nx = {1'b0, lfsr_ff[gmz_pkg::LFSR_WIDTH-1:1]};
      if (lfsr_ff[0]) begin
         lfsr_nx = lfsr_nx ^ gmz_pkg::LFSR_TAPS;
      end
      count = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]);
      unique case (count)
         3'd2:    idx = {1'b0, lfsr_nx[0]};
         3'd3:    idx = mod3(lfsr_nx);
         3'd4:    idx = lfsr_nx[1:0];
         default: idx = 2'd0;
      endcase
   end

   always_comb begin
      logic [1:0] j;
      j = 2'd0;
      dir_in = dir_ff;
      for (int i = 0; i < 4; i++) begin
         if (mask[i]) begin
            if (j == idx) begin
               dir_in = 2'(i);
            end
            j = j + 2'd1;
         end
      end
   end

   always_comb begin
      lfsr_in = lfsr_ff;
      if (ctl.load) begin
         lfsr_in = (ctl.seed == '0) ? gmz_pkg::LFSR_ONE : ctl.seed;
      end else if (ctl.step) begin
         lfsr_in = lfsr_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= gmz_pkg::LFSR_ONE;
      end else begin
         lfsr_ff <= lfsr_in;
      end
      if (ctl.step) begin
         dir_ff <= dir_in;
      end
   end

   assign dir = dir_ff;

   `GMZ_ASSERT(a_lfsr_nonzero, lfsr_ff != '0, "lfsr reached zero")

endmodule

### rtl/core/grid_maze_generate_and_solve_core.sv
// ----------------------------------------------------------------------------
// grid_maze_generate_and_solve_core
// maze grid in one cell memory plus a walk stack memory: clear, generate,
// solve and read commands
// ----------------------------------------------------------------------------
// One request at a time, one response per request. After reset the core
// sweeps all 2**(clog2(W)+clog2(H)) cell memory entries (512 by default)
// before it takes a request. Clear repeats the same sweep; read fetches one
// cell. Generate carves cells along a random walk, then closes with a visited
// sweep over every memory entry. Solve starts with a path sweep over every
// entry, then searches cell by cell and marks each path cell. The cell memory
// has a single read port, which serves every neighbour probe and every
// read-modify-write.
`include "assert_macros.svh"

module grid_maze_generate_and_solve_core #(
   parameter int unsigned GRID_WIDTH  = 32,
   parameter int unsigned GRID_HEIGHT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [4:0]  req_start_x,
   input  logic [3:0]  req_start_y,
   input  logic [4:0]  req_end_x,
   input  logic [3:0]  req_end_y,
   input  logic [15:0] req_seed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [3:0]  rsp_walls,
   output logic        rsp_on_path,
   output logic        rsp_seen
);

   localparam int unsigned XW    = $clog2(GRID_WIDTH);
   localparam int unsigned YW    = $clog2(GRID_HEIGHT);
   localparam int unsigned AW    = XW + YW;
   localparam int unsigned DEPTH = 1 << AW;
   localparam int unsigned CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int unsigned SW    = $clog2(CELLS);
   localparam int unsigned PW    = SW + 1;

   typedef enum logic [4:0] {
      ST_INIT, ST_IDLE, ST_FILL, ST_DONE, ST_RD_W,
      ST_G_ST, ST_G_RD, ST_G_CHK, ST_G_CUR, ST_G_C1, ST_G_C2, ST_G_POP,
      ST_SW_RD, ST_SW_WR,
      ST_V_BEGIN, ST_V_INIT, ST_V_DIR, ST_V_NCHK, ST_V_BACK, ST_V_BK2, ST_V_BK3,
      ST_V_PRD, ST_V_PCL, ST_V_PWR, ST_V_TRD, ST_V_TWR
   } state_type;

   state_type state_ff;

   gmz_pkg::cell_type cell_mem [DEPTH];
   logic [AW-1:0]     stack_mem [CELLS];

   gmz_pkg::cell_type cell_rdata_ff, cell_wdata;
   logic              cell_re, cell_we;
   logic [AW-1:0]     cell_raddr, cell_waddr;
   logic [AW-1:0]     stk_rdata_ff, stk_wdata;
   logic              stk_re, stk_we;
   logic [SW-1:0]     stk_raddr, stk_waddr;

   logic [1:0]        cmd_ff;
   logic [AW-1:0]     start_ff, target_ff, cur_ff, nb_ff, pa_ff, addr_ff;
   logic              ok_ff;
   gmz_pkg::cell_type cur_cell_ff;
   logic [3:0]        cwalls_ff, mask_ff;
   logic [2:0]        d_ff;
   logic [PW-1:0]     sp_ff, k_ff;
   logic              rsp_valid_ff, rsp_found_ff, rsp_on_path_ff, rsp_seen_ff;
   logic [3:0]        rsp_walls_ff;

   logic              accept, start_ok, end_ok;
   logic              cmd_solve, cmd_read;
   logic [AW-1:0]     start_in, target_in;
   logic [PW-1:0]     sp_m1, sp_m2;
   logic [AW-1:0]     nb_d, nb_pick;
   logic [2:0]        back_d;
   logic [1:0]        pick_dir;
   gmz_pkg::pick_ctl_type pick_ctl;

   function automatic logic in_grid(input logic [AW-1:0] c, input logic [1:0] d);
      logic [XW-1:0] x;
      logic [YW-1:0] y;
      logic          r;
      x = c[XW-1:0];
      y = c[AW-1:XW];
      unique case (d)
         gmz_pkg::DIR_TOP:    r = (y != '0);
         gmz_pkg::DIR_RIGHT:  r = (x != XW'(GRID_WIDTH - 1));
         gmz_pkg::DIR_BOTTOM: r = (y != YW'(GRID_HEIGHT - 1));
         default:             r = (x != '0);
      endcase
      return r;
   endfunction

   function automatic logic [AW-1:0] nb(input logic [AW-1:0] c, input logic [1:0] d);
      logic [XW-1:0] x;
      logic [YW-1:0] y;
      logic [AW-1:0] r;
      x = c[XW-1:0];
      y = c[AW-1:XW];
      unique case (d)
         gmz_pkg::DIR_TOP:    r = {y - YW'(1), x};
         gmz_pkg::DIR_RIGHT:  r = {y, x + XW'(1)};
         gmz_pkg::DIR_BOTTOM: r = {y + YW'(1), x};
         default:             r = {y, x - XW'(1)};
      endcase
      return r;
   endfunction

   assign accept    = req_valid && req_ready;
   assign start_ok  = (32'(req_start_x) < GRID_WIDTH) && (32'(req_start_y) < GRID_HEIGHT);
   assign end_ok    = (32'(req_end_x) < GRID_WIDTH) && (32'(req_end_y) < GRID_HEIGHT);
   assign start_in  = {YW'(req_start_y), XW'(req_start_x)};
   assign target_in = {YW'(req_end_y), XW'(req_end_x)};
   assign sp_m1     = sp_ff - PW'(1);
   assign sp_m2     = sp_ff - PW'(2);
   assign nb_d      = nb(cur_ff, d_ff[1:0]);
   assign nb_pick   = nb(cur_ff, pick_dir);
   assign cmd_solve = (cmd_ff == gmz_pkg::CMD_SOLVE);
   assign cmd_read  = (cmd_ff == gmz_pkg::CMD_READ);

   always_comb begin
      back_d = 3'd4;
      for (int k = 0; k < 4; k++) begin
         if (in_grid(stk_rdata_ff, 2'(k)) && nb(stk_rdata_ff, 2'(k)) == cur_ff) begin
            back_d = 3'(k + 1);
         end
      end
   end

   always_comb begin
      pick_ctl.load = accept && (req_command == gmz_pkg::CMD_GEN);
      pick_ctl.seed = req_seed;
      pick_ctl.step = (state_ff == ST_G_CUR) && (mask_ff != '0);
   end

   gmz_pick u_pick (
      .clock (clock),
      .reset (reset),
      .ctl   (pick_ctl),
      .mask  (mask_ff),
      .dir   (pick_dir)
   );

   // memory port control
   always_comb begin
      cell_re    = 1'b0;
      cell_raddr = cur_ff;
      cell_we    = 1'b0;
      cell_waddr = cur_ff;
      cell_wdata = cell_rdata_ff;
      stk_re     = 1'b0;
      stk_raddr  = sp_m1[SW-1:0];
      stk_we     = 1'b0;
      stk_waddr  = sp_ff[SW-1:0];
      stk_wdata  = cur_ff;
      unique case (state_ff)
         ST_INIT, ST_FILL: begin
            cell_we    = 1'b1;
            cell_waddr = addr_ff;
            cell_wdata = gmz_pkg::cell_type'{walls: gmz_pkg::WALL_ALL,
                                             visited: 1'b0, path: 1'b0};
         end
         ST_IDLE: begin
            cell_re    = accept && start_ok &&
                         (req_command == gmz_pkg::CMD_GEN || req_command == gmz_pkg::CMD_READ);
            cell_raddr = start_in;
         end
         ST_G_ST: begin
            cell_we            = 1'b1;
            cell_waddr         = start_ff;
            cell_wdata.visited = 1'b1;
            stk_we             = 1'b1;
            stk_waddr          = '0;
            stk_wdata          = start_ff;
         end
         ST_G_RD: begin
            cell_re    = (d_ff == 3'd4) || in_grid(cur_ff, d_ff[1:0]);
            cell_raddr = (d_ff == 3'd4) ? cur_ff : nb_d;
         end
         ST_G_CUR: begin
            stk_re    = (mask_ff == '0) && (sp_m1 != '0);
            stk_raddr = sp_m2[SW-1:0];
         end
         ST_G_C1: begin
            cell_we          = 1'b1;
            cell_waddr       = cur_ff;
            cell_wdata       = cur_cell_ff;
            cell_wdata.walls = cur_cell_ff.walls & ~(4'd1 << pick_dir);
            cell_re          = 1'b1;
            cell_raddr       = nb_pick;
         end
         ST_G_C2: begin
            cell_we            = 1'b1;
            cell_waddr         = nb_pick;
            cell_wdata.walls   = cell_rdata_ff.walls & ~(4'd1 << (pick_dir + 2'd2));
            cell_wdata.visited = 1'b1;
            stk_we             = sp_ff < PW'(CELLS);
            stk_wdata          = nb_pick;
         end
         ST_SW_RD: begin
            cell_re    = 1'b1;
            cell_raddr = addr_ff;
         end
         ST_SW_WR: begin
            cell_we    = 1'b1;
            cell_waddr = addr_ff;
            if (cmd_ff == gmz_pkg::CMD_GEN) begin
               cell_wdata.visited = 1'b0;
            end else begin
               cell_wdata.path = 1'b0;
            end
         end
         ST_V_BEGIN: begin
            cell_re    = ok_ff;
            cell_raddr = start_ff;
         end
         ST_V_INIT: begin
            cell_we    = 1'b1;
            cell_waddr = start_ff;
            if (start_ff == target_ff) begin
               cell_wdata.path = 1'b1;
            end else begin
               cell_wdata.visited = 1'b1;
               stk_we             = 1'b1;
               stk_waddr          = '0;
               stk_wdata          = start_ff;
            end
         end
         ST_V_DIR: begin
            cell_re    = (d_ff != 3'd4) && in_grid(cur_ff, d_ff[1:0]) &&
                         !cwalls_ff[d_ff[1:0]];
            cell_raddr = nb_d;
         end
         ST_V_NCHK: begin
            if (!cell_rdata_ff.visited && nb_ff != target_ff) begin
               cell_we            = 1'b1;
               cell_waddr         = nb_ff;
               cell_wdata.visited = 1'b1;
               stk_we             = sp_ff < PW'(CELLS);
               stk_wdata          = nb_ff;
            end
         end
         ST_V_BACK: begin
            stk_re    = sp_m1 != '0;
            stk_raddr = sp_m2[SW-1:0];
         end
         ST_V_BK2: begin
            cell_re    = 1'b1;
            cell_raddr = stk_rdata_ff;
         end
         ST_V_PRD: begin
            stk_re    = 1'b1;
            stk_raddr = k_ff[SW-1:0];
         end
         ST_V_PCL: begin
            cell_re    = 1'b1;
            cell_raddr = stk_rdata_ff;
         end
         ST_V_PWR: begin
            cell_we         = 1'b1;
            cell_waddr      = pa_ff;
            cell_wdata.path = 1'b1;
         end
         ST_V_TRD: begin
            cell_re    = 1'b1;
            cell_raddr = target_ff;
         end
         ST_V_TWR: begin
            cell_we         = 1'b1;
            cell_waddr      = target_ff;
            cell_wdata.path = 1'b1;
         end
         default: ;
      endcase
   end

   // cell and stack memories
   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      if (cell_re) begin
         cell_rdata_ff <= cell_mem[cell_raddr];
      end
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rdata_ff <= stack_mem[stk_raddr];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         addr_ff      <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_INIT: begin
               addr_ff <= addr_ff + AW'(1);
               if (addr_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff         <= req_command;
                  start_ff       <= start_in;
                  target_ff      <= target_in;
                  ok_ff          <= start_ok && end_ok;
                  rsp_found_ff   <= 1'b0;
                  rsp_walls_ff   <= '0;
                  rsp_on_path_ff <= 1'b0;
                  rsp_seen_ff    <= 1'b0;
                  addr_ff        <= '0;
                  cur_ff         <= start_in;
                  unique case (req_command)
                     gmz_pkg::CMD_CLEAR: state_ff <= ST_FILL;
                     gmz_pkg::CMD_GEN:   state_ff <= start_ok ? ST_G_ST : ST_DONE;
                     gmz_pkg::CMD_SOLVE: state_ff <= ST_SW_RD;
                     default:            state_ff <= start_ok ? ST_RD_W : ST_DONE;
                  endcase
               end
            end
            ST_FILL: begin
               addr_ff <= addr_ff + AW'(1);
               if (addr_ff == '1) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            ST_RD_W: begin
               rsp_walls_ff   <= cell_rdata_ff.walls;
               rsp_on_path_ff <= cell_rdata_ff.path;
               rsp_seen_ff    <= cell_rdata_ff.visited;
               state_ff       <= ST_DONE;
            end
            ST_G_ST: begin
               sp_ff    <= PW'(1);
               d_ff     <= '0;
               mask_ff  <= '0;
               state_ff <= ST_G_RD;
            end
            ST_G_RD: begin
               if (d_ff == 3'd4) begin
                  state_ff <= ST_G_CUR;
               end else if (in_grid(cur_ff, d_ff[1:0])) begin
                  state_ff <= ST_G_CHK;
               end else begin
                  d_ff <= d_ff + 3'd1;
               end
            end
            ST_G_CHK: begin
               if (!cell_rdata_ff.visited) begin
                  mask_ff[d_ff[1:0]] <= 1'b1;
               end
               d_ff     <= d_ff + 3'd1;
               state_ff <= ST_G_RD;
            end
            ST_G_CUR: begin
               cur_cell_ff <= cell_rdata_ff;
               if (mask_ff != '0) begin
                  state_ff <= ST_G_C1;
               end else begin
                  sp_ff <= sp_m1;
                  if (sp_m1 == '0) begin
                     addr_ff  <= '0;
                     state_ff <= ST_SW_RD;
                  end else begin
                     state_ff <= ST_G_POP;
                  end
               end
            end
            ST_G_C1: begin
               state_ff <= ST_G_C2;
            end
            ST_G_C2: begin
               if (sp_ff < PW'(CELLS)) begin
                  sp_ff  <= sp_ff + PW'(1);
                  cur_ff <= nb_pick;
               end
               d_ff     <= '0;
               mask_ff  <= '0;
               state_ff <= ST_G_RD;
            end
            ST_G_POP: begin
               cur_ff   <= stk_rdata_ff;
               d_ff     <= '0;
               mask_ff  <= '0;
               state_ff <= ST_G_RD;
            end
            ST_SW_RD: begin
               state_ff <= ST_SW_WR;
            end
            ST_SW_WR: begin
               addr_ff <= addr_ff + AW'(1);
               if (addr_ff != '1) begin
                  state_ff <= ST_SW_RD;
               end else if (cmd_ff == gmz_pkg::CMD_GEN) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_V_BEGIN;
               end
            end
            ST_V_BEGIN: begin
               state_ff <= ok_ff ? ST_V_INIT : ST_DONE;
            end
            ST_V_INIT: begin
               if (start_ff == target_ff) begin
                  rsp_found_ff <= 1'b1;
                  state_ff     <= ST_DONE;
               end else begin
                  cwalls_ff <= cell_rdata_ff.walls;
                  sp_ff     <= PW'(1);
                  cur_ff    <= start_ff;
                  d_ff      <= '0;
                  state_ff  <= ST_V_DIR;
               end
            end
            ST_V_DIR: begin
               nb_ff <= nb_d;
               if (d_ff == 3'd4) begin
                  state_ff <= ST_V_BACK;
               end else if (in_grid(cur_ff, d_ff[1:0]) && !cwalls_ff[d_ff[1:0]]) begin
                  state_ff <= ST_V_NCHK;
               end else begin
                  d_ff <= d_ff + 3'd1;
               end
            end
            ST_V_NCHK: begin
               if (cell_rdata_ff.visited) begin
                  d_ff     <= d_ff + 3'd1;
                  state_ff <= ST_V_DIR;
               end else if (nb_ff == target_ff) begin
                  k_ff     <= '0;
                  state_ff <= ST_V_PRD;
               end else begin
                  if (sp_ff < PW'(CELLS)) begin
                     sp_ff     <= sp_ff + PW'(1);
                     cur_ff    <= nb_ff;
                     cwalls_ff <= cell_rdata_ff.walls;
                  end
                  d_ff     <= '0;
                  state_ff <= ST_V_DIR;
               end
            end
            ST_V_BACK: begin
               sp_ff    <= sp_m1;
               state_ff <= (sp_m1 == '0) ? ST_DONE : ST_V_BK2;
            end
            ST_V_BK2: begin
               d_ff     <= back_d;
               cur_ff   <= stk_rdata_ff;
               state_ff <= ST_V_BK3;
            end
            ST_V_BK3: begin
               cwalls_ff <= cell_rdata_ff.walls;
               state_ff  <= ST_V_DIR;
            end
            ST_V_PRD: begin
               state_ff <= ST_V_PCL;
            end
            ST_V_PCL: begin
               pa_ff    <= stk_rdata_ff;
               state_ff <= ST_V_PWR;
            end
            ST_V_PWR: begin
               k_ff     <= k_ff + PW'(1);
               state_ff <= (k_ff + PW'(1) == sp_ff) ? ST_V_TRD : ST_V_PRD;
            end
            ST_V_TRD: begin
               state_ff <= ST_V_TWR;
            end
            ST_V_TWR: begin
               rsp_found_ff <= 1'b1;
               state_ff     <= ST_DONE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready   = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_walls   = rsp_walls_ff;
   assign rsp_on_path = rsp_on_path_ff;
   assign rsp_seen    = rsp_seen_ff;

   `GMZ_ASSERT(a_cell_clash, cell_we && cell_re |-> cell_waddr != cell_raddr, "cell port clash")
   `GMZ_ASSERT_ALWAYS(a_sp_bound, reset || sp_ff <= PW'(CELLS), "stack pointer past depth")
   `GMZ_ASSERT(a_found_cmd, rsp_valid_ff && rsp_found_ff |-> cmd_solve, "found outside solve")
   `GMZ_ASSERT(a_walls_cmd, rsp_valid_ff && rsp_walls_ff != '0 |-> cmd_read, "walls outside read")

endmodule

### tb/sv/tb_grid_maze_generate_and_solve_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_maze_generate_and_solve_core
// drives clear, generate, solve and read requests into the maze core, mirrors
// the grid, the carving walk and the search in a scoreboard class, and checks
// every response field against the mirrored grid
// ----------------------------------------------------------------------------

class maze_scoreboard;
   localparam int GW = 32;
   localparam int GH = 16;
   localparam int NCELL = GW * GH;

   logic [3:0]  walls_mem [NCELL];
   bit          seen_mem [NCELL];
   bit          path_mem [NCELL];
   int          walk [NCELL];
   logic [15:0] lfsr;
   int          errors;

   typedef struct {
      logic       found;
      logic [3:0] walls;
      logic       on_path;
      logic       seen;
   } maze_rsp_type;

   maze_rsp_type pending[$];

   function new();
      errors = 0;
      lfsr = gmz_pkg::LFSR_ONE;
      wipe();
   endfunction

   function void wipe();
      for (int i = 0; i < NCELL; i++) begin
         walls_mem[i] = gmz_pkg::WALL_ALL;
         seen_mem[i] = 0;
         path_mem[i] = 0;
      end
   endfunction

   function logic [15:0] lfsr_step();
      logic low;
      low = lfsr[0];
      lfsr = lfsr >> 1;
      if (low) lfsr = lfsr ^ gmz_pkg::LFSR_TAPS;
      return lfsr;
   endfunction

   function int nb(int c, int d);
      int x, y;
      x = c % GW;
      y = c / GW;
      case (d)
         gmz_pkg::DIR_TOP: y = y - 1;
         gmz_pkg::DIR_RIGHT: x = x + 1;
         gmz_pkg::DIR_BOTTOM: y = y + 1;
         default: x = x - 1;
      endcase
      if (x < 0 || x >= GW || y < 0 || y >= GH) return -1;
      return y * GW + x;
   endfunction

   function void carve(int start);
      int sp, c, cnt, pick, n;
      int dirs[4];
      sp = 1;
      seen_mem[start] = 1;
      walk[0] = start;
      while (sp > 0) begin
         c = walk[sp-1];
         cnt = 0;
         for (int d = 0; d < 4; d++) begin
            n = nb(c, d);
            if (n >= 0 && !seen_mem[n]) begin
               dirs[cnt] = d;
               cnt++;
            end
         end
         if (cnt > 0) begin
            pick = dirs[int'(lfsr_step()) % cnt];
            n = nb(c, pick);
            walls_mem[c][pick] = 1'b0;
            walls_mem[n][(pick + 2) % 4] = 1'b0;
            seen_mem[n] = 1;
            if (sp < NCELL) begin
               walk[sp] = n;
               sp++;
            end
         end else sp--;
      end
      for (int i = 0; i < NCELL; i++) seen_mem[i] = 0;
   endfunction

   function logic search(int start, int target);
      int sp, d, c, n, p;
      bit adv;
      if (start == target) begin
         path_mem[start] = 1;
         return 1;
      end
      sp = 1;
      d = 0;
      seen_mem[start] = 1;
      walk[0] = start;
      while (sp > 0) begin
         c = walk[sp-1];
         adv = 0;
         while (d < 4) begin
            n = nb(c, d);
            if (!(n < 0 || seen_mem[n] || walls_mem[c][d])) begin
               if (n == target) begin
                  for (int k = 0; k < sp; k++) path_mem[walk[k]] = 1;
                  path_mem[n] = 1;
                  return 1;
               end
               seen_mem[n] = 1;
               if (sp < NCELL) begin
                  walk[sp] = n;
                  sp++;
               end
               d = 0;
               adv = 1;
               break;
            end
            d++;
         end
         if (!adv) begin
            sp--;
            d = 4;
            if (sp > 0) begin
               p = walk[sp-1];
               for (int k = 0; k < 4; k++) if (nb(p, k) == c) d = k + 1;
            end
         end
      end
      return 0;
   endfunction

   function void note_request(logic [1:0] cmd, int sx, int sy, int ex, int ey,
                              logic [15:0] seed);
      maze_rsp_type r;
      r = '{1'b0, 4'h0, 1'b0, 1'b0};
      case (cmd)
         gmz_pkg::CMD_CLEAR: wipe();
         gmz_pkg::CMD_GEN: begin
            lfsr = (seed != 0) ? seed : gmz_pkg::LFSR_ONE;
            if (sx < GW && sy < GH) carve(sy * GW + sx);
         end
         gmz_pkg::CMD_SOLVE: begin
            for (int i = 0; i < NCELL; i++) path_mem[i] = 0;
            if (sx < GW && sy < GH && ex < GW && ey < GH)
               r.found = search(sy * GW + sx, ey * GW + ex);
         end
         default: if (sx < GW && sy < GH) begin
            r.walls = walls_mem[sy * GW + sx];
            r.on_path = path_mem[sy * GW + sx];
            r.seen = seen_mem[sy * GW + sx];
         end
      endcase
      pending.push_back(r);
   endfunction

   function void check_response(logic found, logic [3:0] walls, logic on_path,
                                logic seen);
      maze_rsp_type e;
      if (pending.size() == 0) begin
         $error("response with no request outstanding");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (found !== e.found) begin
         $error("found exp %0h got %0h", e.found, found);
         errors++;
      end
      if (walls !== e.walls) begin
         $error("walls exp %0h got %0h", e.walls, walls);
         errors++;
      end
      if (on_path !== e.on_path) begin
         $error("on_path exp %0h got %0h", e.on_path, on_path);
         errors++;
      end
      if (seen !== e.seen) begin
         $error("seen exp %0h got %0h", e.seen, seen);
         errors++;
      end
   endfunction
endclass

module tb_grid_maze_generate_and_solve_core;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_command = gmz_pkg::CMD_CLEAR;
   logic [4:0]  req_start_x = 0;
   logic [3:0]  req_start_y = 0;
   logic [4:0]  req_end_x = 0;
   logic [3:0]  req_end_y = 0;
   logic [15:0] req_seed = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_found;
   logic [3:0]  rsp_walls;
   logic        rsp_on_path;
   logic        rsp_seen;

   maze_scoreboard maze_sb = new();
   bit calm = 0;
   bit hold_rsp = 0;

   grid_maze_generate_and_solve_core dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      #400ms;
      $display("tb_grid_maze_generate_and_solve_core failed");
      $finish;
   end

   // response side: random stall plus a long hold-off when asked
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         maze_sb.check_response(rsp_found, rsp_walls, rsp_on_path, rsp_seen);
      rsp_ready <= !hold_rsp && (calm || $urandom_range(99) >= 27);
   end

   task automatic send(logic [1:0] cmd, logic [4:0] sx, logic [3:0] sy,
                       logic [4:0] ex, logic [3:0] ey, logic [15:0] seed);
      if (!calm && $urandom_range(99) < 27) begin
         req_valid <= 0;
         do @(posedge clock); while (!calm && $urandom_range(99) < 27);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x <= ex;
      req_end_y <= ey;
      req_seed <= seed;
      do @(posedge clock); while (!req_ready);
      maze_sb.note_request(cmd, sx, sy, ex, ey, seed);
   endtask

   task automatic send_random(logic [1:0] cmd);
      logic [4:0]  sx, ex;
      logic [3:0]  sy, ey;
      logic [15:0] sd;
      sx = 5'($urandom);
      sy = 4'($urandom);
      ex = 5'($urandom);
      ey = 4'($urandom);
      sd = 16'($urandom);
      send(cmd, sx, sy, ex, ey, sd);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (maze_sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic random_request();
      int k;
      k = $urandom_range(99);
      if (k < 5) send_random(gmz_pkg::CMD_CLEAR);
      else if (k < 15) send_random(gmz_pkg::CMD_GEN);
      else if (k < 35) send_random(gmz_pkg::CMD_SOLVE);
      else send_random(gmz_pkg::CMD_READ);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      // directed
      send(gmz_pkg::CMD_READ, 0, 0, 0, 0, 0);
      send(gmz_pkg::CMD_SOLVE, 0, 0, 31, 15, 0);
      send(gmz_pkg::CMD_READ, 31, 15, 0, 0, 16'hFFFF);
      send(gmz_pkg::CMD_GEN, 0, 0, 0, 0, 16'h0000);
      send(gmz_pkg::CMD_READ, 0, 0, 0, 0, 0);
      send(gmz_pkg::CMD_SOLVE, 0, 0, 31, 15, 0);
      send(gmz_pkg::CMD_READ, 0, 0, 0, 0, 0);
      send(gmz_pkg::CMD_READ, 31, 15, 0, 0, 0);
      send(gmz_pkg::CMD_SOLVE, 5, 5, 5, 5, 0);
      send(gmz_pkg::CMD_READ, 5, 5, 0, 0, 0);
      send(gmz_pkg::CMD_SOLVE, 31, 15, 0, 0, 0);
      send(gmz_pkg::CMD_GEN, 31, 15, 0, 0, 16'hFFFF);
      send(gmz_pkg::CMD_READ, 16, 8, 0, 0, 0);
      send(gmz_pkg::CMD_CLEAR, 31, 15, 31, 15, 16'hFFFF);
      send(gmz_pkg::CMD_GEN, 17, 9, 0, 0, 16'hACE1);
      send(gmz_pkg::CMD_SOLVE, 17, 9, 2, 14, 16'h5555);
      send(gmz_pkg::CMD_READ, 17, 9, 0, 0, 0);
      // pressure: response hold-off while requests keep coming
      hold_rsp = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 6; i++)
            send_random(gmz_pkg::CMD_READ);
      join
      drain();
      for (int i = 0; i < 120; i++) begin
         calm = (i >= 50 && i < 80);
         if (i == 100) drain();
         random_request();
      end
      calm = 0;
      drain();
      repeat (50) @(posedge clock);
      if (maze_sb.errors == 0 && maze_sb.pending.size() == 0)
         $display("tb_grid_maze_generate_and_solve_core passed");
      else
         $display("tb_grid_maze_generate_and_solve_core failed");
      $finish;
   end
endmodule
